// ===== rtl/imu_fp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package imu_fp_pkg;

   localparam int FRAME_LEN = 11;
   localparam int FILL_W = 4;
   localparam int PAYLOAD_BYTES = FRAME_LEN - 3;
   localparam int PAYLOAD_W = 8 * PAYLOAD_BYTES;
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   localparam logic [7:0] SYNC_BYTE = 8'h55;
   localparam logic [7:0] TYPE_MASK = 8'h50;

   localparam logic ST_FRAME   = 1'b0;
   localparam logic ST_HDR_ERR = 1'b1;

   typedef struct packed {
      logic                 status;
      logic [7:0]           frame_type;
      logic [PAYLOAD_W-1:0] payload;
      logic [7:0]           dropped;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/imu_fp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imu_fp_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   accept,
   input  wire  [7:0]            rx_byte,
   output logic                  push,
   output imu_fp_pkg::entry_type entry
);
   import imu_fp_pkg::*;

   localparam logic [FILL_W-1:0] LAST = FILL_W'(FRAME_LEN - 1);

   logic [7:0]        win_ff [FRAME_LEN];
   logic [7:0]        win_in [FRAME_LEN];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              hdr_ok;

   assign hdr_ok = (win_ff[0] == SYNC_BYTE) && ((win_ff[1] & TYPE_MASK) == TYPE_MASK);

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      push    = 1'b0;
      entry   = '0;
      if (accept) begin
         if (fill_ff == LAST) begin
            push = 1'b1;
            if (hdr_ok) begin
               entry.status     = ST_FRAME;
               entry.frame_type = win_ff[1];
               for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                  entry.payload[8*k +: 8] = win_ff[k+2];
               end
               fill_in = '0;
            end else begin
               entry.status  = ST_HDR_ERR;
               entry.dropped = win_ff[0];
               for (int i = 0; i < FRAME_LEN - 2; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[FRAME_LEN-2] = rx_byte;
               fill_in = LAST;
            end
         end else begin
            win_in[fill_ff] = rx_byte;
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

`ifndef ASSERT_OFF
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST) else $error("window fill count out of range");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (accept && fill_ff == LAST)) else $error("result from partial window");
   a_err_keep: assert property (@(posedge clock) disable iff (reset)
      (accept && fill_ff == LAST && !hdr_ok) |=> (fill_ff == LAST))
      else $error("window not held full after header mismatch");
   a_ok_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && fill_ff == LAST && hdr_ok) |=> (fill_ff == '0))
      else $error("window not cleared after frame");
`endif

endmodule
`default_nettype wire

// ===== rtl/imu_fp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imu_fp_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  imu_fp_pkg::entry_type push_entry,
   input  wire                   pop,
   output logic                  full,
   output logic                  not_empty,
   output imu_fp_pkg::entry_type head
);
   import imu_fp_pkg::*;

   entry_type          mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff;
   logic [Q_CNT_W-1:0] count_in;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/imu_fp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module imu_fp_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   q_valid,
   input  imu_fp_pkg::entry_type q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic                  rsp_status,
   output logic [7:0]            rsp_frame_type,
   output logic signed [15:0]    rsp_word_a,
   output logic signed [15:0]    rsp_word_b,
   output logic signed [15:0]    rsp_word_c,
   output logic signed [15:0]    rsp_word_d,
   output logic [7:0]            rsp_dropped_byte
);
   import imu_fp_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic               status_ff;
   logic [7:0]         type_ff;
   logic signed [15:0] word_a_ff;
   logic signed [15:0] word_b_ff;
   logic signed [15:0] word_c_ff;
   logic signed [15:0] word_d_ff;
   logic [7:0]         dropped_ff;

   // little-endian byte pairs from the window payload
   assign q_pop    = q_valid && (!valid_ff || rsp_ready);
   assign valid_in = q_pop || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         status_ff  <= q_head.status;
         type_ff    <= q_head.frame_type;
         word_a_ff  <= $signed(q_head.payload[15:0]);
         word_b_ff  <= $signed(q_head.payload[31:16]);
         word_c_ff  <= $signed(q_head.payload[47:32]);
         word_d_ff  <= $signed(q_head.payload[63:48]);
         dropped_ff <= q_head.dropped;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_frame_type   = type_ff;
   assign rsp_word_a       = word_a_ff;
   assign rsp_word_b       = word_b_ff;
   assign rsp_word_c       = word_c_ff;
   assign rsp_word_d       = word_d_ff;
   assign rsp_dropped_byte = dropped_ff;

endmodule
`default_nettype wire

// ===== rtl/imu_frame_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Byte-stream parser for 11-byte records that open with sync 0x55 and a type byte with bits
// 0x50 set. One word (byte) is taken per cycle while req_ready is high. Each time the window
// fills, one result word leaves: a full frame (type plus four signed little-endian words,
// checksum byte ignored) or a header error naming the dropped first byte, after which the
// window slides by one byte. A result passes through the two-entry result queue and then the
// output register on its way to the rsp port. req_ready falls only while that queue is full,
// that is when the rsp side has stalled long enough to back up the queue.
module imu_frame_parser_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire  [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic               rsp_status,
   output logic [7:0]         rsp_frame_type,
   output logic signed [15:0] rsp_word_a,
   output logic signed [15:0] rsp_word_b,
   output logic signed [15:0] rsp_word_c,
   output logic signed [15:0] rsp_word_d,
   output logic [7:0]         rsp_dropped_byte
);
   import imu_fp_pkg::*;

   logic      accept;
   logic      push;
   logic      pop;
   logic      q_full;
   logic      q_valid;
   entry_type push_entry;
   entry_type head;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   imu_fp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .push    (push),
      .entry   (push_entry)
   );

   imu_fp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_valid),
      .head       (head)
   );

   imu_fp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_head           (head),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_word_a       (rsp_word_a),
      .rsp_word_b       (rsp_word_b),
      .rsp_word_c       (rsp_word_c),
      .rsp_word_d       (rsp_word_d),
      .rsp_dropped_byte (rsp_dropped_byte)
   );

endmodule
`default_nettype wire

// ===== test/tb_imu_frame_parser_unit.sv =====
`timescale 1ns / 1ps
module tb_imu_frame_parser_unit;
   import imu_fp_pkg::*;

   localparam int RESET_CYCLES   = 11;
   localparam int RANDOM_BYTES   = 700;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int MAX_PRINTED    = 60;

   localparam int PHASE_SLOW_RX = 0;
   localparam int PHASE_SLOW_TX = 1;
   localparam int PHASE_NO_IDLE = 2;

   typedef struct packed {
      logic               status;
      logic [7:0]         frame_type;
      logic signed [15:0] word_a;
      logic signed [15:0] word_b;
      logic signed [15:0] word_c;
      logic signed [15:0] word_d;
      logic [7:0]         dropped;
   } frame_result_type;

   typedef struct {
      logic [7:0] value;
      int         phase;
      bit         drain_first;
   } feed_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_status;
   logic [7:0]         rsp_frame_type;
   logic signed [15:0] rsp_word_a;
   logic signed [15:0] rsp_word_b;
   logic signed [15:0] rsp_word_c;
   logic signed [15:0] rsp_word_d;
   logic [7:0]         rsp_dropped_byte;

   feed_item_type    byte_feed_q[$];
   frame_result_type frame_exp_q[$];
   feed_item_type    next_item;

   logic [7:0]  parse_window [FRAME_LEN];
   int unsigned parse_fill = 0;

   int idle_phase = PHASE_SLOW_RX;
   int mismatch_count = 0;
   int bytes_sent = 0;
   int frames_seen = 0;
   int hdr_errors_seen = 0;
   int quiet_cycles = 0;
   int feed_total = 0;
   bit drain_pending = 1'b0;

   imu_frame_parser_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_word_a       (rsp_word_a),
      .rsp_word_b       (rsp_word_b),
      .rsp_word_c       (rsp_word_c),
      .rsp_word_d       (rsp_word_d),
      .rsp_dropped_byte (rsp_dropped_byte)
   );

   always #5 clock = ~clock;

   function automatic int tx_idle_pct(input int phase);
      case (phase)
         PHASE_SLOW_RX: return 14;
         PHASE_SLOW_TX: return 68;
         default:       return 0;
      endcase
   endfunction

   function automatic int rx_idle_pct(input int phase);
      case (phase)
         PHASE_SLOW_RX: return 68;
         PHASE_SLOW_TX: return 14;
         default:       return 0;
      endcase
   endfunction

   // window model: one result each time the window fills
   function automatic void parse_byte(input logic [7:0] rx);
      frame_result_type r;
      int i;
      parse_window[parse_fill] = rx;
      parse_fill++;
      if (parse_fill == FRAME_LEN) begin
         r = '0;
         if (parse_window[0] != SYNC_BYTE || (parse_window[1] & TYPE_MASK) != TYPE_MASK) begin
            r.status  = ST_HDR_ERR;
            r.dropped = parse_window[0];
            for (i = 0; i < FRAME_LEN - 1; i++)
               parse_window[i] = parse_window[i + 1];
            parse_fill = FRAME_LEN - 1;
         end else begin
            r.status     = ST_FRAME;
            r.frame_type = parse_window[1];
            r.word_a     = {parse_window[3], parse_window[2]};
            r.word_b     = {parse_window[5], parse_window[4]};
            r.word_c     = {parse_window[7], parse_window[6]};
            r.word_d     = {parse_window[9], parse_window[8]};
            parse_fill   = 0;
         end
         frame_exp_q.push_back(r);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic push_byte(input logic [7:0] value, input int phase);
      feed_item_type it;
      it.value       = value;
      it.phase       = phase;
      it.drain_first = drain_pending;
      drain_pending  = 1'b0;
      byte_feed_q.push_back(it);
      feed_total++;
   endtask

   task automatic push_frame(input logic [7:0] ftype, input logic [15:0] wa,
                             input logic [15:0] wb, input logic [15:0] wc,
                             input logic [15:0] wd, input logic [7:0] cks, input int phase);
      push_byte(SYNC_BYTE, phase);
      push_byte(ftype, phase);
      push_byte(wa[7:0], phase);
      push_byte(wa[15:8], phase);
      push_byte(wb[7:0], phase);
      push_byte(wb[15:8], phase);
      push_byte(wc[7:0], phase);
      push_byte(wc[15:8], phase);
      push_byte(wd[7:0], phase);
      push_byte(wd[15:8], phase);
      push_byte(cks, phase);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_rx_byte);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (byte_feed_q.size() > 0 &&
                (!byte_feed_q[0].drain_first || frame_exp_q.size() == 0) &&
                $urandom_range(0, 99) >= tx_idle_pct(byte_feed_q[0].phase)) begin
               next_item   = byte_feed_q.pop_front();
               req_valid   <= 1'b1;
               req_rx_byte <= next_item.value;
               idle_phase  <= next_item.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_exp_q.size() == 0) begin
               report_mismatch($sformatf("result word with nothing expected, status %0d",
                                         rsp_status));
            end else begin
               want = frame_exp_q.pop_front();
               if (want.status == ST_FRAME)
                  frames_seen++;
               else
                  hdr_errors_seen++;
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_frame_type !== want.frame_type)
                  report_mismatch($sformatf("frame_type got %h want %h",
                                            rsp_frame_type, want.frame_type));
               if (rsp_word_a !== want.word_a)
                  report_mismatch($sformatf("word_a got %0d want %0d",
                                            rsp_word_a, want.word_a));
               if (rsp_word_b !== want.word_b)
                  report_mismatch($sformatf("word_b got %0d want %0d",
                                            rsp_word_b, want.word_b));
               if (rsp_word_c !== want.word_c)
                  report_mismatch($sformatf("word_c got %0d want %0d",
                                            rsp_word_c, want.word_c));
               if (rsp_word_d !== want.word_d)
                  report_mismatch($sformatf("word_d got %0d want %0d",
                                            rsp_word_d, want.word_d));
               if (rsp_dropped_byte !== want.dropped)
                  report_mismatch($sformatf("dropped_byte got %h want %h",
                                            rsp_dropped_byte, want.dropped));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct(idle_phase));
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      int phase;
      int last_phase;
      int n;
      logic [7:0] t;

      // directed: extreme words, minimal and full type byte
      push_frame(8'h50, 16'h8000, 16'h7fff, 16'hffff, 16'h0000, 8'hff, PHASE_SLOW_RX);
      // bad sync, then the window slides onto a good header
      push_byte(8'h54, PHASE_SLOW_RX);
      push_frame(8'hff, 16'h0001, 16'hfffe, 16'h7f80, 16'h80ff, 8'h00, PHASE_SLOW_RX);
      // type byte missing a mask bit
      push_byte(SYNC_BYTE, PHASE_SLOW_RX);
      push_byte(8'h40, PHASE_SLOW_RX);

      last_phase = PHASE_SLOW_RX;
      while (feed_total < RANDOM_BYTES + 25) begin
         phase = (feed_total * 3) / (RANDOM_BYTES + 25);
         if (phase > PHASE_NO_IDLE)
            phase = PHASE_NO_IDLE;
         if (phase != last_phase)
            drain_pending = 1'b1;
         last_phase = phase;
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            push_frame(8'($urandom_range(0, 255)) | TYPE_MASK, 16'($urandom),
                       16'($urandom), 16'($urandom), 16'($urandom),
                       8'($urandom_range(0, 255)), phase);
         end else if (kind == 7) begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom_range(0, 255)), phase);
         end else if (kind == 8) begin
            t = 8'($urandom_range(0, 255));
            if ((t & TYPE_MASK) == TYPE_MASK)
               t = t ^ ($urandom_range(0, 1) ? 8'h40 : 8'h10);
            push_byte(SYNC_BYTE, phase);
            push_byte(t, phase);
            repeat (9) push_byte(8'($urandom_range(0, 255)), phase);
         end else begin
            n = $urandom_range(0, 7);
            push_byte(SYNC_BYTE, phase);
            push_byte(8'($urandom_range(0, 255)) | TYPE_MASK, phase);
            repeat (n) push_byte(8'($urandom_range(0, 255)), phase);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (byte_feed_q.size() != 0 || req_valid) @(posedge clock);
      while (frame_exp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frame_exp_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", frame_exp_q.size()));

      $display("covered %0d bytes in three idle patterns: %0d frames, %0d header errors",
               bytes_sent, frames_seen, hdr_errors_seen);
      $display("%0d mismatches seen", mismatch_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
